// ===== src/slfp_pkg.sv =====
`default_nettype none

package slfp_pkg;

  // Default depth of the frame store, in bytes.
  localparam int unsigned BufferDepthDefault = 32;

  // Every frame opens with this mark byte.
  localparam logic [7:0] FrameMark = 8'h40;

  // Bytes of a frame beyond its payload: mark, command, length, checksum, trailer.
  localparam logic [8:0] FrameOverhead = 9'd5;

  // Fewest held bytes before a checksum is attempted.
  localparam int unsigned MinHeld = 3;

  // Store position of the first payload byte.
  localparam int unsigned PayloadBase = 3;

  // Largest number of results that one frame emits.
  localparam logic [4:0] MaxResults = 5'd26;

  // Width of the result tdata bus, padded to whole bytes.
  localparam int unsigned OutTdataW = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

endpackage

`default_nettype wire

// ===== src/slfp_store.sv =====
`default_nettype none

module slfp_store import slfp_pkg::*; #(
  parameter int unsigned Depth = BufferDepthDefault,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  // Single write port, single registered read port.
  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/sync_length_checksum_frame_parser.sv =====
// Frame parser for a byte stream with a length byte and an additive checksum.
// Received bytes enter one per transfer on the slave stream (s_axis). Each byte
// is written into the frame store. A frame starts with the mark byte 0x40, then
// the command, the payload length L, the payload and a checksum byte that must
// equal the 8-bit sum of all bytes before it; one trailing byte follows.
// A byte that arrives at position zero without the mark leaves the fill count at
// zero and the block stays ready; any other byte passes the evaluation state
// first. Once enough bytes are held, the check walks the store through one
// shared 8-bit adder, one byte per cycle, and then compares the checksum byte.
// On a match the master stream (m_axis) carries one transfer per payload byte
// (at most 26), or one transfer without data for an empty payload; each payload
// result takes a store read and then an output load, and the empty result takes
// only the output load. tlast marks the final result of a frame. The store's
// single read port serves both the checksum walk and the emit. The block takes
// no byte while a check or an emit is running. Results sit in one output
// register; a stalled receiver holds the emit sequence, not the store. Reset
// clears the fill count and the sequencer; store contents are left as they are
// and are never read before being written in the current frame.
`default_nettype none

module sync_length_checksum_frame_parser import slfp_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Received byte stream.
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] rx_byte
  // Result stream.
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] command, [23:8] random_code, [28:24] payload_len,
  // [33:29] payload_index, [41:34] payload_byte, [47:42] zero
  output logic [OutTdataW-1:0]      m_axis_tdata_o,
  output logic [0:0]                m_axis_tuser_o,   // [0] byte_valid
  output logic                      m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  state_e state_q, state_d;

  // Fill count: the store position that the next byte is written to.
  logic [AW-1:0] fc_q, fc_d;
  // Read pointer of the checksum walk.
  logic [AW-1:0] idx_q, idx_d;
  // Running checksum.
  logic [7:0]    acc_q, acc_d;
  // Payload position being emitted and number of results in this frame.
  logic [4:0]    k_q, k_d;
  logic [4:0]    emit_q, emit_d;
  // High when the store read data belongs to the checksum walk.
  logic          tvld_q;

  // Header bytes, captured as they are written.
  logic [7:0] cmd_q, len_q, code_hi_q, code_lo_q;

  // Output register.
  logic                 m_valid_q;
  logic [7:0]           o_cmd_q;
  logic [15:0]          o_code_q;
  logic [4:0]           o_len_q;
  logic [4:0]           o_idx_q;
  logic [7:0]           o_byte_q;
  logic                 o_bvalid_q;
  logic                 o_last_q;

  logic          we;
  logic [AW-1:0] raddr;
  logic [7:0]    rd;
  logic          load;
  logic          accept;
  logic [AW-1:0] fc_inc;
  logic [AW-1:0] sum_last;
  logic          last_res;

  slfp_store #(
    .Depth (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fc_q),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign fc_inc   = (fc_q == AW'(BUFFER_DEPTH - 1)) ? '0 : fc_q + AW'(1);
  // The walk sums positions up to fill count - 3; fill count - 2 holds the checksum.
  assign sum_last = fc_q - AW'(2);
  assign last_res = (len_q == 8'd0) || (k_q == emit_q - 5'd1);

  always_comb begin
    state_d         = state_q;
    fc_d            = fc_q;
    idx_d           = idx_q;
    acc_d           = acc_q;
    k_d             = k_q;
    emit_d          = emit_q;
    raddr           = idx_q;
    we              = 1'b0;
    load            = 1'b0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          we = 1'b1;
          if (fc_q == '0 && s_axis_tdata_i != FrameMark) begin
            fc_d = '0;
          end else begin
            fc_d    = fc_inc;
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (fc_q < AW'(MinHeld) ||
            9'(fc_q) < ({1'b0, len_q} + FrameOverhead)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (tvld_q) begin
          acc_d = acc_q + rd;
        end
        if (idx_q == sum_last) begin
          state_d = ST_CMP;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_CMP: begin
        if (rd == acc_q) begin
          fc_d    = '0;
          k_d     = '0;
          emit_d  = (len_q > {3'b000, MaxResults}) ? MaxResults : len_q[4:0];
          state_d = (len_q == 8'd0) ? ST_EMIT_WR : ST_EMIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        raddr   = AW'(k_q) + AW'(PayloadBase);
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        // Keep the payload address so the read data holds while the receiver stalls.
        raddr = AW'(k_q) + AW'(PayloadBase);
        if (!m_valid_q || m_axis_tready_i) begin
          load = 1'b1;
          if (last_res) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 5'd1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fc_q      <= '0;
      idx_q     <= '0;
      acc_q     <= '0;
      k_q       <= '0;
      emit_q    <= '0;
      tvld_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      k_q     <= k_d;
      emit_q  <= emit_d;
      tvld_q  <= (state_q == ST_SUM);
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Header capture; these positions are always written within the frame being checked.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (fc_q == AW'(1)) begin
        cmd_q <= s_axis_tdata_i;
      end
      if (fc_q == AW'(2)) begin
        len_q <= s_axis_tdata_i;
      end
      if (fc_q == AW'(3)) begin
        code_hi_q <= s_axis_tdata_i;
      end
      if (fc_q == AW'(4)) begin
        code_lo_q <= s_axis_tdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_cmd_q    <= cmd_q;
      o_code_q   <= {code_hi_q, code_lo_q};
      o_len_q    <= len_q[4:0];
      o_idx_q    <= k_q;
      o_byte_q   <= (len_q == 8'd0) ? 8'd0 : rd;
      o_bvalid_q <= (len_q != 8'd0);
      o_last_q   <= last_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0, o_byte_q, o_idx_q, o_len_q, o_code_q, o_cmd_q};
  assign m_axis_tuser_o  = o_bvalid_q;
  assign m_axis_tlast_o  = o_last_q;

  // A check only starts with at least three bytes held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (fc_q >= AW'(MinHeld)))
    else $error("checksum compare with too few bytes held");

  // The walk never reads past the checksum position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (idx_q <= sum_last))
    else $error("checksum walk ran past the checksum byte");

  // While a frame is emitted the fill count is already cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |-> (fc_q == '0))
    else $error("fill count not cleared during emit");

  // A payload read stays within the emit count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD) |-> (k_q < emit_q))
    else $error("payload index beyond emit count");

  // The last result of a frame returns the sequencer to accept bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_res) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after last result");

endmodule

`default_nettype wire
